// ----- rtl/qxmm_pkg.sv -----
// ----------------------------------------------------------------------------
// Quad X motor mixer package
// Shared types, widths, register indexes and reset values of the mixer.
// ----------------------------------------------------------------------------
package qxmm_pkg;

   // Field widths.
   localparam int unsigned ThrW   = 12;
   localparam int unsigned DriveW = 16;
   localparam int unsigned PwmW   = 12;
   localparam int unsigned CountW = 16;
   localparam int unsigned CsrW   = 16;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned Motors = 4;

   // Width of the wide mixer sum: base plus three signed drives.
   localparam int unsigned MixW = 19;

   // Operating modes, in the encoding reported on the result channel.
   typedef enum logic [1:0] {
      MODE_WAIT_ARM = 2'd0,
      MODE_WAIT_THR = 2'd1,
      MODE_RUN      = 2'd2,
      MODE_EXIT     = 2'd3
   } mode_type;

   // Configuration register indexes.
   typedef enum logic [CsrIdxW-1:0] {
      CSR_ARM_THROTTLE_LEVEL = 3'd0,
      CSR_THROTTLE_OFFSET    = 3'd1,
      CSR_LOW_THROTTLE_LEVEL = 3'd2,
      CSR_LOW_THROTTLE_TICKS = 3'd3,
      CSR_BASE_THRUST_CAP    = 3'd4,
      CSR_OUTPUT_MAX         = 3'd5
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [ThrW-1:0]   ArmThrottleLevelRst = 12'd1100;
   localparam logic [ThrW-1:0]   ThrottleOffsetRst   = 12'd1000;
   localparam logic [ThrW-1:0]   LowThrottleLevelRst = 12'd10;
   localparam logic [CountW-1:0] LowThrottleTicksRst = 16'd300;
   localparam logic [ThrW-1:0]   BaseThrustCapRst    = 12'd800;
   localparam logic [PwmW-1:0]   OutputMaxRst        = 12'd1000;

   // Motor compare values, front right, front left, rear right, rear left.
   typedef logic [Motors-1:0][PwmW-1:0] motor_vec_type;

   // Rate controller drives passed to the mixer.
   typedef struct packed {
      logic signed [DriveW-1:0] roll;
      logic signed [DriveW-1:0] pitch;
      logic signed [DriveW-1:0] yaw;
   } drive_type;

endpackage

// ----- rtl/qxmm_req_if.sv -----
// ----------------------------------------------------------------------------
// Quad X motor mixer request channel
// Valid/ready channel carrying one control tick to the mixer.
// ----------------------------------------------------------------------------
interface qxmm_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      armed;
   logic        [qxmm_pkg::ThrW-1:0]          throttle_raw;
   logic signed [qxmm_pkg::DriveW-1:0]        roll_rate_drive;
   logic signed [qxmm_pkg::DriveW-1:0]        pitch_rate_drive;
   logic signed [qxmm_pkg::DriveW-1:0]        yaw_rate_drive;

   modport source (
      output valid, armed, throttle_raw, roll_rate_drive, pitch_rate_drive,
             yaw_rate_drive,
      input  ready
   );

   modport sink (
      input  valid, armed, throttle_raw, roll_rate_drive, pitch_rate_drive,
             yaw_rate_drive,
      output ready
   );
endinterface

// ----- rtl/qxmm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Quad X motor mixer response channel
// Valid/ready channel carrying motor values, reset pulses and mode.
// ----------------------------------------------------------------------------
interface qxmm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [qxmm_pkg::PwmW-1:0]     front_right_pwm;
   logic [qxmm_pkg::PwmW-1:0]     front_left_pwm;
   logic [qxmm_pkg::PwmW-1:0]     rear_right_pwm;
   logic [qxmm_pkg::PwmW-1:0]     rear_left_pwm;
   logic                          pid_reset;
   logic                          yaw_reset;
   logic [1:0]                    mode;

   modport source (
      output valid, front_right_pwm, front_left_pwm, rear_right_pwm, rear_left_pwm,
             pid_reset, yaw_reset, mode,
      input  ready
   );

   modport sink (
      input  valid, front_right_pwm, front_left_pwm, rear_right_pwm, rear_left_pwm,
             pid_reset, yaw_reset, mode,
      output ready
   );
endinterface

// ----- rtl/qxmm_mix.sv -----
// ----------------------------------------------------------------------------
// Quad X motor mixer arithmetic
// Applies the X-frame signs to the base thrust and clamps each motor value.
// ----------------------------------------------------------------------------
module qxmm_mix (
   input  logic [qxmm_pkg::ThrW-1:0] base_thrust,
   input  qxmm_pkg::drive_type       drive,
   input  logic [qxmm_pkg::PwmW-1:0] output_max,
   output qxmm_pkg::motor_vec_type   motor
);

   localparam int unsigned MixW = qxmm_pkg::MixW;
   localparam int unsigned ExtW = MixW - qxmm_pkg::DriveW;

   logic signed [MixW-1:0] base_s;
   logic signed [MixW-1:0] roll_s;
   logic signed [MixW-1:0] pitch_s;
   logic signed [MixW-1:0] yaw_s;
   logic signed [MixW-1:0] max_s;
   logic signed [MixW-1:0] mix [qxmm_pkg::Motors];

   // Extend everything to the full sum width so that nothing wraps.
   assign base_s  = signed'({{(MixW - qxmm_pkg::ThrW){1'b0}}, base_thrust});
   assign roll_s  = signed'({{ExtW{drive.roll[qxmm_pkg::DriveW-1]}}, drive.roll});
   assign pitch_s = signed'({{ExtW{drive.pitch[qxmm_pkg::DriveW-1]}}, drive.pitch});
   assign yaw_s   = signed'({{ExtW{drive.yaw[qxmm_pkg::DriveW-1]}}, drive.yaw});
   assign max_s   = signed'({{(MixW - qxmm_pkg::PwmW){1'b0}}, output_max});

   // X-frame mix: front right, front left, rear right, rear left.
   assign mix[0] = base_s + roll_s + pitch_s + yaw_s;
   assign mix[1] = base_s - roll_s + pitch_s - yaw_s;
   assign mix[2] = base_s + roll_s - pitch_s - yaw_s;
   assign mix[3] = base_s - roll_s - pitch_s + yaw_s;

   // Clamp each sum to the range from zero to the output maximum.
   always_comb begin
      for (int i = 0; i < qxmm_pkg::Motors; i++) begin
         if (mix[i] < 0) begin
            motor[i] = '0;
         end else if (mix[i] > max_s) begin
            motor[i] = output_max;
         end else begin
            motor[i] = mix[i][qxmm_pkg::PwmW-1:0];
         end
      end
   end

endmodule

// ----- rtl/quad_x_motor_mixer_arming_core.sv -----
// ----------------------------------------------------------------------------
// Quad X motor mixer with arming sequence
// Control tick in, four motor compare values and controller resets out.
// ----------------------------------------------------------------------------
// Each request on req carries one control tick: the arm flag, the raw throttle
// and the roll, pitch and yaw rate drives. Each request gives exactly one
// response on rsp with the four motor values, the PID and yaw reset pulses and
// the mode after the tick. Both channels use valid/ready.
// A request is captured in an input register; the arming state machine and the
// mixer then produce the response into an output register, which drives
// rsp.valid. One request is taken every cycle while the receiver does not
// stall; the loop through the mode, low-throttle counter and motor registers
// sets that rate.
// When the receiver stalls, the response is held and the input register still
// takes one more request; req.ready falls only when both registers are full.
// Reset (synchronous, active high) returns the mode to wait-for-arm, clears the
// counter and motors, and loads the register defaults. The csr port writes a
// register by index; writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_arming_core (
   input  logic                              clock,
   input  logic                              reset,
   qxmm_req_if.sink                          req,
   qxmm_rsp_if.source                        rsp,
   input  logic                              csr_write_en,
   input  logic [qxmm_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [qxmm_pkg::CsrW-1:0]         csr_data
);

   localparam int unsigned ThrW   = qxmm_pkg::ThrW;
   localparam int unsigned PwmW   = qxmm_pkg::PwmW;
   localparam int unsigned CountW = qxmm_pkg::CountW;

   // Configuration registers.
   logic [ThrW-1:0]   arm_level_ff;
   logic [ThrW-1:0]   offset_ff;
   logic [ThrW-1:0]   low_level_ff;
   logic [CountW-1:0] low_ticks_ff;
   logic [ThrW-1:0]   cap_ff;
   logic [PwmW-1:0]   output_max_ff;

   // Input register.
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic                s1_armed_ff;
   logic [ThrW-1:0]     s1_thr_ff;
   qxmm_pkg::drive_type s1_drive_ff;

   // Arming state.
   qxmm_pkg::mode_type      mode_ff;
   qxmm_pkg::mode_type      mode_in;
   logic [CountW-1:0]       count_ff;
   logic [CountW-1:0]       count_in;
   qxmm_pkg::motor_vec_type motor_ff;
   qxmm_pkg::motor_vec_type motor_in;

   // Output register.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   qxmm_pkg::motor_vec_type pwm_ff;
   qxmm_pkg::motor_vec_type pwm_in;
   logic                    pid_ff;
   logic                    pid_in;
   logic                    yaw_ff;
   logic                    yaw_in;
   qxmm_pkg::mode_type      rsp_mode_ff;

   // Handshake and datapath signals.
   logic                    req_fire;
   logic                    s1_advance;
   logic                    s1_fire;
   qxmm_pkg::mode_type      mode_eff;
   logic signed [ThrW:0]    temp;
   logic                    low_thr;
   logic [ThrW-1:0]         base;
   logic [CountW-1:0]       count_inc;
   logic                    start_run;
   qxmm_pkg::motor_vec_type mix_motor;

   // Handshake: the input register moves on when the output register is free.
   assign s1_advance   = !rsp_valid_ff || rsp.ready;
   assign s1_fire      = s1_valid_ff && s1_advance;
   assign req.ready    = !s1_valid_ff || s1_advance;
   assign req_fire     = req.valid && req.ready;
   assign s1_valid_in  = req_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         arm_level_ff  <= qxmm_pkg::ArmThrottleLevelRst;
         offset_ff     <= qxmm_pkg::ThrottleOffsetRst;
         low_level_ff  <= qxmm_pkg::LowThrottleLevelRst;
         low_ticks_ff  <= qxmm_pkg::LowThrottleTicksRst;
         cap_ff        <= qxmm_pkg::BaseThrustCapRst;
         output_max_ff <= qxmm_pkg::OutputMaxRst;
      end else if (csr_write_en) begin
         case (qxmm_pkg::csr_index_type'(csr_index))
            qxmm_pkg::CSR_ARM_THROTTLE_LEVEL: arm_level_ff  <= csr_data[ThrW-1:0];
            qxmm_pkg::CSR_THROTTLE_OFFSET:    offset_ff     <= csr_data[ThrW-1:0];
            qxmm_pkg::CSR_LOW_THROTTLE_LEVEL: low_level_ff  <= csr_data[ThrW-1:0];
            qxmm_pkg::CSR_LOW_THROTTLE_TICKS: low_ticks_ff  <= csr_data[CountW-1:0];
            qxmm_pkg::CSR_BASE_THRUST_CAP:    cap_ff        <= csr_data[ThrW-1:0];
            qxmm_pkg::CSR_OUTPUT_MAX:         output_max_ff <= csr_data[PwmW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_armed_ff       <= req.armed;
         s1_thr_ff         <= req.throttle_raw;
         s1_drive_ff.roll  <= req.roll_rate_drive;
         s1_drive_ff.pitch <= req.pitch_rate_drive;
         s1_drive_ff.yaw   <= req.yaw_rate_drive;
      end
   end

   // Offset throttle, low-throttle test and clamped base thrust.
   assign temp      = signed'({1'b0, s1_thr_ff}) - signed'({1'b0, offset_ff});
   assign low_thr   = temp < signed'({1'b0, low_level_ff});
   assign count_inc = count_ff + CountW'(1);
   assign start_run = s1_thr_ff > arm_level_ff;

   always_comb begin
      if (temp < 0) begin
         base = '0;
      end else if (temp > signed'({1'b0, cap_ff})) begin
         base = cap_ff;
      end else begin
         base = temp[ThrW-1:0];
      end
   end

   qxmm_mix u_mix (
      .base_thrust (base),
      .drive       (s1_drive_ff),
      .output_max  (output_max_ff),
      .motor       (mix_motor)
   );

   // Arming state machine: a cleared arm flag forces the exit mode at once.
   assign mode_eff = s1_armed_ff ? mode_ff : qxmm_pkg::MODE_EXIT;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      motor_in = motor_ff;
      pid_in   = 1'b0;
      yaw_in   = 1'b0;
      case (mode_eff)
         qxmm_pkg::MODE_WAIT_ARM, qxmm_pkg::MODE_WAIT_THR: begin
            // Waiting for arm drops straight into waiting for throttle.
            if (mode_eff == qxmm_pkg::MODE_WAIT_ARM) begin
               motor_in = '0;
            end
            mode_in = qxmm_pkg::MODE_WAIT_THR;
            if (start_run) begin
               count_in = '0;
               pid_in   = 1'b1;
               yaw_in   = 1'b1;
               mode_in  = qxmm_pkg::MODE_RUN;
            end
         end
         qxmm_pkg::MODE_RUN: begin
            motor_in = mix_motor;
            if (low_thr) begin
               count_in = count_inc;
               // Sustained low throttle: stop the motors and wait again.
               if (count_inc > low_ticks_ff) begin
                  pid_in   = 1'b1;
                  motor_in = '0;
                  mode_in  = qxmm_pkg::MODE_WAIT_THR;
               end
            end else begin
               count_in = '0;
            end
         end
         qxmm_pkg::MODE_EXIT: begin
            motor_in = '0;
            mode_in  = qxmm_pkg::MODE_WAIT_ARM;
         end
         default: begin
            mode_in = qxmm_pkg::MODE_WAIT_ARM;
         end
      endcase
   end

   // Held motor values are clamped again to the present output maximum.
   always_comb begin
      for (int i = 0; i < qxmm_pkg::Motors; i++) begin
         pwm_in[i] = (motor_in[i] > output_max_ff) ? output_max_ff : motor_in[i];
      end
   end

   // State registers, updated once per processed request.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= qxmm_pkg::MODE_WAIT_ARM;
         count_ff <= '0;
         motor_ff <= '0;
      end else if (s1_fire) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         motor_ff <= motor_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_fire) begin
         pwm_ff      <= pwm_in;
         pid_ff      <= pid_in;
         yaw_ff      <= yaw_in;
         rsp_mode_ff <= mode_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.front_right_pwm = pwm_ff[0];
   assign rsp.front_left_pwm  = pwm_ff[1];
   assign rsp.rear_right_pwm  = pwm_ff[2];
   assign rsp.rear_left_pwm   = pwm_ff[3];
   assign rsp.pid_reset       = pid_ff;
   assign rsp.yaw_reset       = yaw_ff;
   assign rsp.mode            = rsp_mode_ff;

   // Outside the running mode the stored motor values are always zero.
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff != qxmm_pkg::MODE_RUN) |-> (motor_ff == '0))
      else $error("motor values not zero outside running mode");

   // A disarmed request always ends in wait-for-arm.
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_armed_ff) |=> (mode_ff == qxmm_pkg::MODE_WAIT_ARM))
      else $error("disarm did not return to wait-for-arm");

   // A yaw reset only comes with a PID reset on entry to the running mode.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && yaw_ff) |-> (pid_ff && rsp_mode_ff == qxmm_pkg::MODE_RUN))
      else $error("yaw reset without start of running");

   // Every issued motor value respects the output maximum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (pwm_ff[0] <= output_max_ff && pwm_ff[1] <= output_max_ff &&
                        pwm_ff[2] <= output_max_ff && pwm_ff[3] <= output_max_ff))
      else $error("motor value above output maximum");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad X motor mixer testbench
// Sends control ticks into the mixer with random gaps and stalls its response
// channel at random. A scoreboard keeps its own copy of the arming sequence,
// the low-throttle timeout and the X-frame mix, works out the response of
// every accepted request and compares it field by field with what comes out.
// Directed requests come first, then random phases under changing settings.
// ----------------------------------------------------------------------------
module tb;

   localparam int ClockPeriod  = 20;
   localparam int ResetCycles  = 6;
   localparam int CycleLimit   = 400000;
   localparam int DrainCycles  = 6;
   localparam int ReportLimit  = 10;
   localparam int RandomPhases = 9;

   localparam int unsigned ThrW    = qxmm_pkg::ThrW;
   localparam int unsigned DriveW  = qxmm_pkg::DriveW;
   localparam int unsigned PwmW    = qxmm_pkg::PwmW;
   localparam int unsigned CountW  = qxmm_pkg::CountW;
   localparam int unsigned CsrW    = qxmm_pkg::CsrW;
   localparam int unsigned CsrIdxW = qxmm_pkg::CsrIdxW;
   localparam int unsigned Motors  = qxmm_pkg::Motors;

   // Indexes past the end of the register list; writes to them are ignored.
   localparam logic [CsrIdxW-1:0] CsrSpareIdxLow  = 3'd6;
   localparam logic [CsrIdxW-1:0] CsrSpareIdxHigh = 3'd7;

   // One control tick as carried by a request.
   typedef struct packed {
      logic                logic_armed_unused_guard;
      logic                armed;
      logic [ThrW-1:0]     throttle;
      qxmm_pkg::drive_type drive;
   } control_tick_raw_type;

   typedef struct packed {
      logic                armed;
      logic [ThrW-1:0]     throttle;
      qxmm_pkg::drive_type drive;
   } control_tick_type;

   // One response: motors in the order front right, front left, rear right, rear left.
   typedef struct packed {
      qxmm_pkg::motor_vec_type motors;
      logic                    pid_reset;
      logic                    yaw_reset;
      qxmm_pkg::mode_type      mode;
   } motor_output_type;

   // Scoreboard: mirrors the mixer state and queues the expected responses.
   class motor_mix_scoreboard;
      logic [ThrW-1:0]         arm_level;
      logic [ThrW-1:0]         offset;
      logic [ThrW-1:0]         low_level;
      logic [CountW-1:0]       low_ticks;
      logic [ThrW-1:0]         thrust_cap;
      logic [PwmW-1:0]         out_max;
      qxmm_pkg::mode_type      mode;
      logic [CountW-1:0]       low_count;
      qxmm_pkg::motor_vec_type motors;
      motor_output_type        expected_outputs[$];
      int                      failures;
      int                      responses;

      function new();
         arm_level  = qxmm_pkg::ArmThrottleLevelRst;
         offset     = qxmm_pkg::ThrottleOffsetRst;
         low_level  = qxmm_pkg::LowThrottleLevelRst;
         low_ticks  = qxmm_pkg::LowThrottleTicksRst;
         thrust_cap = qxmm_pkg::BaseThrustCapRst;
         out_max    = qxmm_pkg::OutputMaxRst;
         mode       = qxmm_pkg::MODE_WAIT_ARM;
         low_count  = '0;
         motors     = '0;
         failures   = 0;
         responses  = 0;
      endfunction

      function void write_register(logic [CsrIdxW-1:0] index, logic [CsrW-1:0] data);
         case (index)
            qxmm_pkg::CSR_ARM_THROTTLE_LEVEL: arm_level  = data[ThrW-1:0];
            qxmm_pkg::CSR_THROTTLE_OFFSET:    offset     = data[ThrW-1:0];
            qxmm_pkg::CSR_LOW_THROTTLE_LEVEL: low_level  = data[ThrW-1:0];
            qxmm_pkg::CSR_LOW_THROTTLE_TICKS: low_ticks  = data;
            qxmm_pkg::CSR_BASE_THRUST_CAP:    thrust_cap = data[ThrW-1:0];
            qxmm_pkg::CSR_OUTPUT_MAX:         out_max    = data[PwmW-1:0];
            default: ;
         endcase
      endfunction

      function int clamp(int value, int lo, int hi);
         if (value < lo) return lo;
         if (value > hi) return hi;
         return value;
      endfunction

      // Advances the mirrored state by one tick and returns its response.
      function motor_output_type mix_control_tick(control_tick_type tick);
         int               thr;
         int               rx;
         int               ry;
         int               rz;
         int               temp;
         int               base;
         int               m;
         int               sum[Motors];
         motor_output_type mix_out;
         thr = int'(tick.throttle);
         rx  = $signed(tick.drive.roll);
         ry  = $signed(tick.drive.pitch);
         rz  = $signed(tick.drive.yaw);
         mix_out.pid_reset = 1'b0;
         mix_out.yaw_reset = 1'b0;

         // A cleared arm flag overrides whatever mode the block is in.
         if (!tick.armed) mode = qxmm_pkg::MODE_EXIT;

         case (mode)
            qxmm_pkg::MODE_WAIT_ARM, qxmm_pkg::MODE_WAIT_THR: begin
               // Waiting for arm passes straight on to the throttle wait.
               if (mode == qxmm_pkg::MODE_WAIT_ARM) begin
                  motors = '0;
                  mode   = qxmm_pkg::MODE_WAIT_THR;
               end
               if (thr > int'(arm_level)) begin
                  low_count         = '0;
                  mix_out.pid_reset = 1'b1;
                  mix_out.yaw_reset = 1'b1;
                  mode              = qxmm_pkg::MODE_RUN;
               end
            end
            qxmm_pkg::MODE_RUN: begin
               // The low-throttle test uses the signed offset throttle.
               temp = thr - int'(offset);
               if (temp < int'(low_level)) begin
                  low_count = low_count + 1'b1;
               end else begin
                  low_count = '0;
               end
               if (temp < int'(low_level) && low_count > low_ticks) begin
                  mix_out.pid_reset = 1'b1;
                  motors            = '0;
                  mode              = qxmm_pkg::MODE_WAIT_THR;
               end else begin
                  base   = clamp(temp, 0, int'(thrust_cap));
                  sum[0] = base + rx + ry + rz;
                  sum[1] = base - rx + ry - rz;
                  sum[2] = base + rx - ry - rz;
                  sum[3] = base - rx - ry + rz;
                  for (m = 0; m < Motors; m++) begin
                     motors[m] = PwmW'(clamp(sum[m], 0, int'(out_max)));
                  end
               end
            end
            default: begin
               motors = '0;
               mode   = qxmm_pkg::MODE_WAIT_ARM;
            end
         endcase

         // Held motors are clamped again to the current maximum.
         for (m = 0; m < Motors; m++) begin
            mix_out.motors[m] = (motors[m] > out_max) ? out_max : motors[m];
         end
         mix_out.mode = mode;
         return mix_out;
      endfunction

      function void note_request(control_tick_type tick);
         expected_outputs.push_back(mix_control_tick(tick));
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            failures++;
            if (failures <= ReportLimit) begin
               $display("mismatch on %s of response %0d: expected %0d, got %0d",
                        name, responses, want, got);
            end
         end
      endfunction

      function void check_motor_output(motor_output_type got);
         motor_output_type want;
         if (expected_outputs.size() == 0) begin
            failures++;
            if (failures <= ReportLimit) begin
               $display("response with no request outstanding: mode %0d", got.mode);
            end
            return;
         end
         want = expected_outputs.pop_front();
         compare_field("front_right_pwm", want.motors[0], got.motors[0]);
         compare_field("front_left_pwm", want.motors[1], got.motors[1]);
         compare_field("rear_right_pwm", want.motors[2], got.motors[2]);
         compare_field("rear_left_pwm", want.motors[3], got.motors[3]);
         compare_field("pid_reset", want.pid_reset, got.pid_reset);
         compare_field("yaw_reset", want.yaw_reset, got.yaw_reset);
         compare_field("mode", want.mode, got.mode);
         responses++;
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_write_en;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrW-1:0]     csr_data;
   int                  sender_idle_pct   = 0;
   int                  receiver_idle_pct = 0;
   int                  low_burst_left    = 0;
   int unsigned         cycle_count       = 0;
   motor_mix_scoreboard mix_board         = new();

   qxmm_req_if req_ch ();
   qxmm_rsp_if rsp_ch ();

   quad_x_motor_mixer_arming_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Response channel: stalls in random bursts.
   initial begin
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) < receiver_idle_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
         repeat ($urandom_range(0, 15)) @(posedge clock);
      end
   end

   // Every accepted response is checked against the oldest expectation.
   always @(posedge clock) begin
      motor_output_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.motors[0] = rsp_ch.front_right_pwm;
         got.motors[1] = rsp_ch.front_left_pwm;
         got.motors[2] = rsp_ch.rear_right_pwm;
         got.motors[3] = rsp_ch.rear_left_pwm;
         got.pid_reset = rsp_ch.pid_reset;
         got.yaw_reset = rsp_ch.yaw_reset;
         got.mode      = qxmm_pkg::mode_type'(rsp_ch.mode);
         mix_board.check_motor_output(got);
      end
   end

   function automatic control_tick_type control_tick(logic armed, int thr, int roll,
                                                      int pitch, int yaw);
      control_tick_type tick;
      tick.armed       = armed;
      tick.throttle    = ThrW'(thr);
      tick.drive.roll  = DriveW'(roll);
      tick.drive.pitch = DriveW'(pitch);
      tick.drive.yaw   = DriveW'(yaw);
      return tick;
   endfunction

   // Moderate drives half the time, with full-range values and the extremes mixed in.
   function automatic logic [DriveW-1:0] random_drive();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) return DriveW'(int'($urandom_range(0, 800)) - 400);
      if (sel < 85) return DriveW'($urandom);
      case ($urandom_range(0, 3))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   // Builds the next request from the mirrored mode so that most sequences
   // arm, run and time out rather than sit in the wait modes.
   function automatic control_tick_type make_request();
      control_tick_type tick;
      int               thr;
      int               arm_lvl;
      int               off;
      int               low_edge;
      arm_lvl  = int'(mix_board.arm_level);
      off      = int'(mix_board.offset);
      low_edge = off + int'(mix_board.low_level);
      thr      = $urandom_range(0, 4095);

      if (mix_board.mode == qxmm_pkg::MODE_RUN) begin
         if (low_burst_left == 0 && $urandom_range(0, 99) < 8) begin
            low_burst_left = (mix_board.low_ticks <= 40) ?
                             int'(mix_board.low_ticks) + $urandom_range(1, 3) :
                             $urandom_range(1, 10);
         end
         if (low_burst_left > 0) begin
            low_burst_left--;
            if (low_edge > 0) thr = $urandom_range(0, (low_edge > 4096) ? 4095 : low_edge - 1);
         end else if ($urandom_range(0, 99) < 75) begin
            thr = off + $urandom_range(0, int'(mix_board.thrust_cap) + 40);
            if (thr > 4095) thr = 4095;
         end
      end else begin
         low_burst_left = 0;
         if ($urandom_range(0, 99) < 50 && arm_lvl < 4095) begin
            thr = $urandom_range(arm_lvl + 1, 4095);
         end
      end

      tick.armed       = ($urandom_range(0, 99) >= 3);
      tick.throttle    = ThrW'(thr);
      tick.drive.roll  = random_drive();
      tick.drive.pitch = random_drive();
      tick.drive.yaw   = random_drive();
      return tick;
   endfunction

   // Offers one request, after an optional gap, and waits for it to be taken.
   task automatic send_request(control_tick_type tick);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.armed            <= tick.armed;
      req_ch.throttle_raw     <= tick.throttle;
      req_ch.roll_rate_drive  <= tick.drive.roll;
      req_ch.pitch_rate_drive <= tick.drive.pitch;
      req_ch.yaw_rate_drive   <= tick.drive.yaw;
      do @(posedge clock); while (!req_ch.ready);
      mix_board.note_request(tick);
   endtask

   // Holds off requests until every response is in and the pipeline is empty.
   task automatic wait_until_idle();
      req_ch.valid <= 1'b0;
      while (mix_board.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] index, logic [CsrW-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_data     <= data;
      @(posedge clock);
      mix_board.write_register(index, data);
   endtask

   // Writes every register, plus one index past the end of the list.
   task automatic program_settings(logic [CsrW-1:0] arm_lvl, logic [CsrW-1:0] off,
                                   logic [CsrW-1:0] low_lvl, logic [CsrW-1:0] ticks,
                                   logic [CsrW-1:0] cap, logic [CsrW-1:0] max_out);
      write_csr(qxmm_pkg::CSR_ARM_THROTTLE_LEVEL, arm_lvl);
      write_csr(qxmm_pkg::CSR_THROTTLE_OFFSET, off);
      write_csr($urandom_range(0, 1) ? CsrSpareIdxLow : CsrSpareIdxHigh, CsrW'($urandom));
      write_csr(qxmm_pkg::CSR_LOW_THROTTLE_LEVEL, low_lvl);
      write_csr(qxmm_pkg::CSR_LOW_THROTTLE_TICKS, ticks);
      write_csr(qxmm_pkg::CSR_BASE_THRUST_CAP, cap);
      write_csr(qxmm_pkg::CSR_OUTPUT_MAX, max_out);
      csr_write_en <= 1'b0;
   endtask

   // A 12-bit setting, usually in a useful range, with junk in the unused top bits.
   function automatic logic [CsrW-1:0] random_level(int typical_hi);
      logic [ThrW-1:0] level;
      level = ($urandom_range(0, 99) < 80) ? ThrW'($urandom_range(0, typical_hi)) :
                                             ThrW'($urandom);
      return {4'($urandom), level};
   endfunction

   // Main sequence.
   initial begin
      int request_count;
      logic [CsrW-1:0] ticks;
      reset                   <= 1'b1;
      csr_write_en            <= 1'b0;
      csr_index               <= qxmm_pkg::CSR_ARM_THROTTLE_LEVEL;
      csr_data                <= '0;
      req_ch.valid            <= 1'b0;
      req_ch.armed            <= 1'b0;
      req_ch.throttle_raw     <= '0;
      req_ch.roll_rate_drive  <= '0;
      req_ch.pitch_rate_drive <= '0;
      req_ch.yaw_rate_drive   <= '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under the reset settings.
      sender_idle_pct   = 15;
      receiver_idle_pct = 15;
      // Disarm straight out of wait-for-arm.
      send_request(control_tick(1'b0, 4095, 32767, 32767, 32767));
      send_request(control_tick(1'b1, 0, 0, 0, 0));
      // Throttle at the arm level does not start; one above it does.
      send_request(control_tick(1'b1, 1100, 0, 0, 0));
      send_request(control_tick(1'b1, 1101, 5, 5, 5));
      send_request(control_tick(1'b1, 4095, 32767, 32767, 32767));
      send_request(control_tick(1'b1, 4095, -32768, -32768, -32768));
      send_request(control_tick(1'b1, 1500, 100, -50, 25));
      send_request(control_tick(1'b1, 1500, -32768, 32767, 0));
      send_request(control_tick(1'b1, 1750, -1, 1, -300));
      // Negative offset throttle, then either side of the low level.
      send_request(control_tick(1'b1, 0, 200, 200, 200));
      send_request(control_tick(1'b1, 1009, 0, 0, 0));
      send_request(control_tick(1'b1, 1010, 0, 0, 0));
      // Disarm while running, then arm and start in a single tick.
      send_request(control_tick(1'b0, 2000, 0, 0, 0));
      send_request(control_tick(1'b1, 2000, 400, 0, 0));

      // Short timeout, wide limits: the block is still running across the write.
      wait_until_idle();
      program_settings(16'd0, 16'd0, 16'd4095, 16'd2, 16'd4095, 16'd4095);
      send_request(control_tick(1'b1, 4095, 32767, -32768, 0));
      send_request(control_tick(1'b1, 4094, 1000, 1000, 1000));
      send_request(control_tick(1'b1, 0, 0, 0, 0));
      send_request(control_tick(1'b1, 100, 0, 0, 0));
      send_request(control_tick(1'b1, 0, 0, 0, 0));
      send_request(control_tick(1'b1, 1, -7, 9, 3));

      // Random phases, the first two at the extremes of every register.
      for (int phase = 0; phase < RandomPhases; phase++) begin
         wait_until_idle();
         request_count = 100;
         if (phase == 0) begin
            program_settings('0, '0, '0, '0, '0, '0);
         end else if (phase == 1) begin
            program_settings('1, '1, '1, '1, '1, '1);
            request_count = 40;
         end else begin
            ticks = ($urandom_range(0, 99) < 80) ? CsrW'($urandom_range(0, 12)) :
                                                   CsrW'($urandom);
            program_settings(random_level(2500), random_level(2000), random_level(400),
                             ticks, random_level(4095), random_level(4095));
         end

         // The last phase runs with no idling on either side.
         if (phase == RandomPhases - 1) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end else begin
            sender_idle_pct   = 20 * $urandom_range(0, 2);
            receiver_idle_pct = 20 * $urandom_range(0, 2);
         end
         repeat (request_count) send_request(make_request());
      end

      wait_until_idle();
      if (mix_board.failures == 0 && mix_board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
